FILE: design/piq_pkg.sv
`default_nettype none
package piq_pkg;

    localparam int DefQueueDepth = 16;

    // op codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    // push result codes
    localparam logic [1:0] DROP_NONE = 2'd0;
    localparam logic [1:0] DROP_DUP  = 2'd1;
    localparam logic [1:0] DROP_FULL = 2'd2;

    // configuration register indexes
    localparam logic CFG_EOF_MASK    = 1'b0;
    localparam logic CFG_DETECT_DUTY = 1'b1;

    localparam logic [7:0]  EOF_MASK_RESET    = 8'd1;
    localparam logic [7:0]  DETECT_DUTY_RESET = 8'd128;
    localparam logic [16:0] DETECT_PRIORITY   = 17'h10000;
    localparam logic [17:0] WAIT_DETECT       = 18'h3FFFF;

    typedef struct packed {
        logic        op;
        logic [15:0] current_index;
        logic [7:0]  status;
        logic [15:0] entry_index;
        logic [7:0]  duty;
        logic [15:0] priority_req;
        logic        detect_marker;
    } t_in_item;

    typedef struct packed {
        logic signed [17:0] next_index;
        logic [4:0]         entry_count;
        logic [15:0]        highest_priority;
        logic               detect_seen;
        logic [1:0]         push_dropped;
    } t_out_item;

    typedef struct packed {
        logic [15:0] index;
        logic [7:0]  duty;
        logic [16:0] prio;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

endpackage
`default_nettype wire

FILE: design/piq_cell.sv
`default_nettype none
module piq_cell
    import piq_pkg::*;
(
    input  wire         i_clk,
    input  t_cell_ctrl  i_ctrl,
    input  wire         i_occ,
    input  t_entry      i_new,
    input  t_entry      i_left,
    input  wire         i_left_after,
    input  t_entry      i_right,
    output t_entry      o_entry,
    output logic        o_after,
    output logic        o_match
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_entry = r_entry;
    // new entry goes behind this one when its priority is not lower
    assign o_after = i_occ && (r_entry.prio <= i_new.prio);
    assign o_match = i_occ && (r_entry.duty == i_new.duty) && (r_entry.index == i_new.index);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.pop) begin
            n_entry = i_right;
        end else if (i_ctrl.ins && !o_after) begin
            n_entry = i_left_after ? i_new : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

FILE: design/priority_index_queue_top.sv
// channel   dir  handshake                    payload
// in        in   i_in_valid / o_in_ready      i_in_data  (t_in_item)
// out       out  o_out_valid / i_out_ready    o_out_data (t_out_item)
// cfg       in   i_cfg_we                     i_cfg_index, i_cfg_data
//
// one item per cycle while the output is not stalled: a push or pop updates the whole cell row in the transfer cycle,
// with the compare of every cell against the incoming entry done in parallel
// the result is registered and shows in the cycle after the input transfer
// a new item is taken while the output register is empty or being drained
// synchronous active-low reset clears count, saved index and tracking, and loads config defaults
`default_nettype none
module priority_index_queue_top
    import piq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DefQueueDepth
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_item  o_out_data,
    input  wire        i_cfg_we,
    input  wire        i_cfg_index,
    input  wire [7:0]  i_cfg_data
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic [CntW-1:0] r_count, n_count;
    logic [15:0]     r_saved_index, n_saved_index;
    logic            r_saved_valid, n_saved_valid;
    logic [15:0]     r_max, n_max;
    logic            r_detect, n_detect;
    logic [7:0]      r_eof_mask, r_detect_duty;
    logic            r_out_valid;
    t_out_item       r_out, n_out;

    t_entry          w_entry [QUEUE_DEPTH];
    logic            w_after [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_match;
    t_entry          w_new;
    t_cell_ctrl      w_ctrl;
    logic            w_accept;
    logic            w_dup, w_full, w_hit;
    logic [17:0]     w_empty_ans;
    logic [31:0]     w_cnt_ext;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_new.index = i_in_data.entry_index;
    assign w_new.duty  = i_in_data.duty;
    assign w_new.prio  = i_in_data.detect_marker ? DETECT_PRIORITY
                                                 : {1'b0, i_in_data.priority_req};

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            localparam logic [CntW-1:0] Pos = CntW'(gi);
            piq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_occ        (Pos < r_count),
                .i_new        (w_new),
                .i_left       ((gi == 0) ? w_new : w_entry[(gi == 0) ? 0 : gi - 1]),
                .i_left_after ((gi == 0) ? 1'b1 : w_after[(gi == 0) ? 0 : gi - 1]),
                .i_right      (w_entry[(gi == QUEUE_DEPTH - 1) ? gi : gi + 1]),
                .o_entry      (w_entry[gi]),
                .o_after      (w_after[gi]),
                .o_match      (w_match[gi])
            );
        end
    endgenerate

    assign w_dup  = |w_match;
    assign w_full = (r_count >= CntW'(QUEUE_DEPTH));
    assign w_hit  = ((w_entry[0].duty & i_in_data.status) != 8'd0) &&
                    ((w_entry[0].index == i_in_data.current_index) ||
                     (w_entry[0].duty == r_detect_duty));
    assign w_empty_ans = r_saved_valid ? {2'b00, r_saved_index}
                       : ((i_in_data.status & r_eof_mask) != 8'd0)
                         ? ({2'b00, i_in_data.current_index} + 18'd1) : 18'd0;

    always_comb begin
        n_count       = r_count;
        n_saved_index = r_saved_index;
        n_saved_valid = r_saved_valid;
        n_max         = r_max;
        n_detect      = r_detect;
        w_ctrl        = '0;
        n_out.next_index   = '0;
        n_out.push_dropped = DROP_NONE;
        if (i_in_data.op == OP_PUSH) begin
            if (i_in_data.detect_marker) begin
                n_detect = 1'b1;
            end else if (i_in_data.priority_req > r_max) begin
                n_max = i_in_data.priority_req;
            end
            if (r_count == '0) begin
                n_saved_index = i_in_data.current_index;
                n_saved_valid = 1'b1;
            end
            if (w_dup) begin
                n_out.push_dropped = DROP_DUP;
            end else if (w_full) begin
                n_out.push_dropped = DROP_FULL;
            end else begin
                w_ctrl.ins = w_accept;
                n_count    = r_count + CntW'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_out.next_index = w_empty_ans;
                n_saved_valid    = 1'b0;
            end else if (!w_hit) begin
                n_out.next_index = (w_entry[0].duty == r_detect_duty) ? WAIT_DETECT
                                                                      : {2'b00, w_entry[0].index};
            end else begin
                w_ctrl.pop = w_accept;
                n_count    = r_count - CntW'(1);
                if (r_count == CntW'(1)) begin
                    n_max            = '0;
                    n_detect         = 1'b0;
                    n_out.next_index = w_empty_ans;
                    n_saved_valid    = 1'b0;
                end else begin
                    n_out.next_index = {2'b00, w_entry[1].index};
                end
            end
        end
        w_cnt_ext              = 32'(n_count);
        n_out.entry_count      = w_cnt_ext[4:0];
        n_out.highest_priority = n_max;
        n_out.detect_seen      = n_detect;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_saved_index <= '0;
            r_saved_valid <= 1'b0;
            r_max         <= '0;
            r_detect      <= 1'b0;
            r_eof_mask    <= EOF_MASK_RESET;
            r_detect_duty <= DETECT_DUTY_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EOF_MASK:    r_eof_mask    <= i_cfg_data;
                    CFG_DETECT_DUTY: r_detect_duty <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_count       <= n_count;
                r_saved_index <= n_saved_index;
                r_saved_valid <= n_saved_valid;
                r_max         <= n_max;
                r_detect      <= n_detect;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // an empty queue carries no priority tracking
    a_empty_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_max == '0) && !r_detect)
        else $error("tracking not cleared with empty queue");

    // a non-empty queue always holds the index saved at its first push
    a_saved_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_saved_valid)
        else $error("saved index lost while queue occupied");

    a_dup_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_data.op == OP_PUSH) && w_dup) |=> $stable(r_count))
        else $error("duplicate push changed the count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(QUEUE_DEPTH))
        else $error("count beyond depth");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_priority_index_queue_top.sv
module tb_priority_index_queue_top;
    import piq_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int PhaseItems = 263;

    // running copy of the queue; predicts one result per accepted input transfer
    class piq_tracker;
        t_entry      slots[DefQueueDepth];
        int unsigned count;
        logic [15:0] saved_idx;
        bit          saved_ok;
        logic [15:0] top_prio;
        bit          detect_on;
        logic [7:0]  eof_mask;
        logic [7:0]  detect_duty;
        t_out_item   pending[$];
        int unsigned fails;

        function new();
            foreach (slots[k]) slots[k] = '0;
            count = 0;
            saved_idx = '0;
            saved_ok = 0;
            top_prio = '0;
            detect_on = 0;
            eof_mask = EOF_MASK_RESET;
            detect_duty = DETECT_DUTY_RESET;
            fails = 0;
        endfunction

        function void set_reg(logic idx, logic [7:0] value);
            if (idx == CFG_EOF_MASK) begin
                eof_mask = value;
            end else begin
                detect_duty = value;
            end
        endfunction

        function logic [17:0] empty_answer(logic [15:0] cur, logic [7:0] status);
            if (saved_ok) begin
                saved_ok = 0;
                return {2'b00, saved_idx};
            end
            if ((status & eof_mask) != 0) return {2'b00, cur} + 18'd1;
            return '0;
        endfunction

        function logic [1:0] push_entry(t_in_item it);
            logic [16:0] p;
            int unsigned pos;
            // tracking is updated even when the push gets dropped
            if (it.detect_marker) begin
                detect_on = 1;
                p = DETECT_PRIORITY;
            end else begin
                p = {1'b0, it.priority_req};
                if (it.priority_req > top_prio) top_prio = it.priority_req;
            end
            if (count == 0) begin
                saved_idx = it.current_index;
                saved_ok = 1;
            end
            for (int k = 0; k < count; k++) begin
                if (slots[k].duty == it.duty && slots[k].index == it.entry_index) return DROP_DUP;
            end
            if (count >= DefQueueDepth) return DROP_FULL;
            pos = 0;
            while (pos < count && slots[pos].prio <= p) pos++;
            for (int k = count; k > pos; k--) slots[k] = slots[k - 1];
            slots[pos] = '{index: it.entry_index, duty: it.duty, prio: p};
            count++;
            return DROP_NONE;
        endfunction

        function logic [17:0] next_answer(t_in_item it);
            bit hit;
            if (count == 0) return empty_answer(it.current_index, it.status);
            hit = (slots[0].duty & it.status) != 0 &&
                  (slots[0].index == it.current_index || slots[0].duty == detect_duty);
            if (!hit) begin
                if (slots[0].duty == detect_duty) return WAIT_DETECT;
                return {2'b00, slots[0].index};
            end
            for (int k = 1; k < count; k++) slots[k - 1] = slots[k];
            count--;
            if (count == 0) begin
                top_prio = '0;
                detect_on = 0;
                return empty_answer(it.current_index, it.status);
            end
            return {2'b00, slots[0].index};
        endfunction

        function void note_item(t_in_item it);
            t_out_item r;
            r = '0;
            if (it.op == OP_PUSH) begin
                r.push_dropped = push_entry(it);
            end else begin
                r.next_index = next_answer(it);
            end
            r.entry_count = count[4:0];
            r.highest_priority = top_prio;
            r.detect_seen = detect_on;
            pending.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $error("output transfer with no result outstanding");
                fails++;
                return;
            end
            want = pending.pop_front();
            if (got.next_index !== want.next_index) begin
                $error("next_index expected %0d actual %0d", want.next_index, got.next_index);
                fails++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count expected %0d actual %0d", want.entry_count, got.entry_count);
                fails++;
            end
            if (got.highest_priority !== want.highest_priority) begin
                $error("highest_priority expected %0d actual %0d",
                       want.highest_priority, got.highest_priority);
                fails++;
            end
            if (got.detect_seen !== want.detect_seen) begin
                $error("detect_seen expected %0d actual %0d", want.detect_seen, got.detect_seen);
                fails++;
            end
            if (got.push_dropped !== want.push_dropped) begin
                $error("push_dropped expected %0d actual %0d",
                       want.push_dropped, got.push_dropped);
                fails++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    t_in_item   i_in_data = '0;
    logic       i_out_ready = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = CFG_EOF_MASK;
    logic [7:0] i_cfg_data = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_data;

    piq_tracker  tracker;
    int unsigned idle_pct = 31;
    int unsigned cycles = 0;

    priority_index_queue_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("priority_index_queue_top regression: fail");
            $finish;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_result(o_out_data);
        end
    end

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_item(it);
    endtask

    // only called with the block drained
    task automatic set_config(logic [7:0] eof_mask, logic [7:0] detect_duty);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_EOF_MASK;
        i_cfg_data <= eof_mask;
        @(posedge i_clk);
        tracker.set_reg(CFG_EOF_MASK, eof_mask);
        i_cfg_index <= CFG_DETECT_DUTY;
        i_cfg_data <= detect_duty;
        @(posedge i_clk);
        tracker.set_reg(CFG_DETECT_DUTY, detect_duty);
        i_cfg_we <= 1'b0;
    endtask

    task automatic finish_phase();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending.size() != 0);
    endtask

    function automatic t_in_item random_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item push_item(logic [15:0] cur, logic [15:0] idx, logic [7:0] duty,
                                           logic [15:0] prio, logic marker);
        t_in_item it;
        it = random_item();
        it.op = OP_PUSH;
        it.current_index = cur;
        it.entry_index = idx;
        it.duty = duty;
        it.priority_req = prio;
        it.detect_marker = marker;
        return it;
    endfunction

    function automatic t_in_item next_item(logic [15:0] cur, logic [7:0] status);
        t_in_item it;
        it = random_item();
        it.op = OP_NEXT;
        it.current_index = cur;
        it.status = status;
        return it;
    endfunction

    // pushes from small pools (duplicates, equal priorities) and pops mostly aimed at the head
    function automatic t_in_item make_item(int unsigned push_pct);
        t_in_item it;
        t_entry   head;
        it = random_item();
        head = tracker.slots[0];
        if ($urandom_range(99) < 10) return it;
        if ($urandom_range(99) < push_pct) begin
            it.op = OP_PUSH;
            if ($urandom_range(3) != 0) it.entry_index = 16'($urandom_range(5));
            case ($urandom_range(4))
                0: it.duty = 8'h01;
                1: it.duty = 8'h02;
                2: it.duty = tracker.detect_duty;
                3: it.duty = 8'h81;
                default: ;
            endcase
            if ($urandom_range(3) != 0) it.priority_req = 16'($urandom_range(7));
            it.detect_marker = ($urandom_range(9) == 0);
        end else begin
            it.op = OP_NEXT;
            if (tracker.count != 0 && $urandom_range(99) < 75) begin
                it.current_index = head.index;
                it.status = $urandom_range(1) ? head.duty : (head.duty | 8'($urandom));
            end
        end
        return it;
    endfunction

    task automatic run_directed();
        send_item(next_item(16'h0000, 8'h00));
        send_item(next_item(16'hFFFF, 8'hFF));
        send_item(push_item(16'h1234, 16'h0007, 8'h80, 16'hFFFF, 1'b1));
        send_item(push_item(16'h0000, 16'hFFFF, 8'hFF, 16'h0000, 1'b0));
        // ordinary head, index mismatch
        send_item(next_item(16'h0001, 8'hFF));
        send_item(next_item(16'hFFFF, 8'h01));
        // detect head waits until its duty bit shows in status
        send_item(next_item(16'h0000, 8'h7F));
        send_item(next_item(16'h0000, 8'h80));
        send_item(push_item(16'hFFFF, 16'h0005, 8'h01, 16'h0000, 1'b0));
        send_item(push_item(16'h0000, 16'h0006, 8'h01, 16'h0000, 1'b0));
        for (int k = 0; k < 14; k++) begin
            send_item(push_item(16'($urandom), 16'h0100 + 16'(k), 8'(1 << (k % 8)),
                                16'(k * 4681 + 3), 1'b0));
        end
        send_item(push_item(16'h0000, 16'h0200, 8'h04, 16'h0001, 1'b0));
        send_item(push_item(16'h0000, 16'h0005, 8'h01, 16'hFFFF, 1'b0));
    endtask

    initial begin
        int unsigned push_pct;
        tracker = new();
        push_pct = 50;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        finish_phase();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_config(8'h00, 8'h00);
                1: set_config(8'hFF, 8'hFF);
                2: set_config(8'($urandom), 8'($urandom));
                default: set_config(EOF_MASK_RESET, DETECT_DUTY_RESET);
            endcase
            idle_pct = (ph == 1) ? 0 : 31;
            for (int k = 0; k < PhaseItems; k++) begin
                if (k % 50 == 0) begin
                    case ($urandom_range(2))
                        0: push_pct = 25;
                        1: push_pct = 50;
                        default: push_pct = 85;
                    endcase
                end
                send_item(make_item(push_pct));
            end
            finish_phase();
        end
        repeat (4) @(posedge i_clk);
        if (tracker.fails == 0) begin
            $display("priority_index_queue_top regression: pass");
        end else begin
            $display("priority_index_queue_top regression: fail");
        end
        $finish;
    end

endmodule
